[src/chi_pkg.sv]
// chi_pkg: shared types, command codes and constants of the chained index hash table.
// Used by every module under src; depends on nothing.
`default_nettype none

package chi_pkg;

   localparam int CMD_WIDTH          = 3;
   localparam int KEY_WIDTH          = 32;
   localparam int INDEX_WIDTH        = 12;
   localparam int DEF_HEAD_COUNT     = 1024;
   localparam int DEF_INDEX_CAPACITY = 4096;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD    = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_FIRST  = 3'd2,
      CMD_NEXT   = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   // one head or link entry: empty mark plus element index
   typedef struct packed {
      logic                   empty;
      logic [INDEX_WIDTH-1:0] index;
   } slot_type;

   localparam int SLOT_WIDTH = $bits(slot_type);
   localparam slot_type EMPTY_SLOT = '{empty: 1'b1, index: '1};

   typedef struct packed {
      logic [CMD_WIDTH-1:0]   cmd;
      logic [KEY_WIDTH-1:0]   key;
      logic [INDEX_WIDTH-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] result_index;
      logic                   result_valid;
      logic                   status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_RANGE,
      RSP_HEAD,
      RSP_LINK
   } rsp_sel_type;

   typedef struct packed {
      logic        capture;
      logic        add_write;
      logic        unlink_head;
      logic        walk_start;
      logic        walk_step;
      logic        walk_fix;
      logic        sweep_write;
      logic        respond;
      rsp_sel_type rsp_sel;
   } ctrl_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] cmd;
      logic                 in_range;
      logic                 head_hit;
      logic                 head_empty;
      logic                 link_hit;
      logic                 link_empty;
      logic                 walk_last;
      logic                 sweep_last;
   } stat_type;

endpackage

`default_nettype wire

[src/chi_ram.sv]
// chi_ram: generic single write port, single read port RAM with registered read data.
// Depends on chi_pkg for default sizes.
`default_nettype none

module chi_ram
   import chi_pkg::*;
#(
   parameter int WIDTH = SLOT_WIDTH,
   parameter int DEPTH = DEF_HEAD_COUNT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/chi_ctrl.sv]
// chi_ctrl: sequencing state machine of the chained index hash table.
// Depends on chi_pkg; drives chi_datapath through ctrl_type, reads back stat_type.
`default_nettype none

module chi_ctrl
   import chi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [CMD_WIDTH-1:0] req_cmd,
   input  wire stat_type             stat,
   output logic                      busy,
   output ctrl_type                  ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_cmd == CMD_CLEAR) ? ST_CLEAR : ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (stat.cmd == CMD_REMOVE && stat.in_range && !stat.head_hit
                && !stat.head_empty) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (stat.link_hit || stat.link_empty || stat.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.rsp_sel = RSP_NONE;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_INIT: begin
            ctrl.sweep_write = 1'b1;
         end
         ST_IDLE: begin
            ctrl.capture = start;
         end
         ST_EXEC: begin
            ctrl.respond = 1'b1;
            unique case (stat.cmd)
               CMD_ADD: begin
                  if (stat.in_range) begin
                     ctrl.add_write = 1'b1;
                  end else begin
                     ctrl.rsp_sel = RSP_RANGE;
                  end
               end
               CMD_REMOVE: begin
                  priority if (!stat.in_range) begin
                     ctrl.rsp_sel = RSP_RANGE;
                  end else if (stat.head_hit) begin
                     ctrl.unlink_head = 1'b1;
                  end else if (!stat.head_empty) begin
                     // chain walk follows; answer comes from the walk
                     ctrl.respond    = 1'b0;
                     ctrl.walk_start = 1'b1;
                  end else begin
                     // empty chain: nothing to unlink
                     ctrl.rsp_sel = RSP_NONE;
                  end
               end
               CMD_FIRST: begin
                  ctrl.rsp_sel = RSP_HEAD;
               end
               CMD_NEXT: begin
                  ctrl.rsp_sel = stat.in_range ? RSP_LINK : RSP_RANGE;
               end
               default: begin
                  ctrl.rsp_sel = RSP_NONE;
               end
            endcase
         end
         ST_WALK: begin
            priority if (stat.link_hit) begin
               ctrl.walk_fix = 1'b1;
               ctrl.respond  = 1'b1;
            end else if (stat.link_empty || stat.walk_last) begin
               ctrl.respond = 1'b1;
            end else begin
               ctrl.walk_step = 1'b1;
            end
         end
         ST_CLEAR: begin
            ctrl.sweep_write = 1'b1;
            ctrl.respond     = stat.sweep_last;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/chi_datapath.sv]
// chi_datapath: head and link memories, request registers, walk and sweep counters,
// result register. Depends on chi_pkg and chi_ram; commanded by chi_ctrl.
`default_nettype none

module chi_datapath
   import chi_pkg::*;
#(
   parameter int HEAD_COUNT     = DEF_HEAD_COUNT,
   parameter int INDEX_CAPACITY = DEF_INDEX_CAPACITY
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire req_type  req_payload,
   input  wire ctrl_type ctrl,
   output stat_type      stat,
   output logic          rsp_strobe,
   output rsp_type       rsp_payload
);

   localparam int HEAD_AW    = $clog2(HEAD_COUNT);
   localparam int LINK_DEPTH = (INDEX_CAPACITY < (2 ** INDEX_WIDTH)) ?
                               INDEX_CAPACITY : (2 ** INDEX_WIDTH);
   localparam int LINK_AW    = $clog2(LINK_DEPTH);
   localparam int STEP_W     = $clog2(INDEX_CAPACITY);

   logic [CMD_WIDTH-1:0]   cmd_ff;
   logic [HEAD_AW-1:0]     slot_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   slot_type               cur_ff, idx_link_ff;
   logic [STEP_W-1:0]      steps_ff, steps_in;
   logic [HEAD_AW-1:0]     sweep_ff, sweep_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   strobe_ff;

   slot_type               head_q, link_q;
   logic                   head_wr_en, link_wr_en, link_rd_en;
   logic [HEAD_AW-1:0]     head_wr_addr, req_slot;
   slot_type               head_wr_data, link_wr_data;
   logic [LINK_AW-1:0]     link_wr_addr, link_rd_addr;

   assign req_slot = req_payload.key[HEAD_AW-1:0] & HEAD_AW'(HEAD_COUNT - 1);

   // head slots: sweep, push, or unlink of the first element
   always_comb begin
      head_wr_en = ctrl.sweep_write | ctrl.add_write | ctrl.unlink_head;
      priority if (ctrl.sweep_write) begin
         head_wr_addr = sweep_ff;
         head_wr_data = EMPTY_SLOT;
      end else if (ctrl.add_write) begin
         head_wr_addr = slot_ff;
         head_wr_data = '{empty: 1'b0, index: idx_ff};
      end else begin
         head_wr_addr = slot_ff;
         head_wr_data = link_q;
      end
   end

   chi_ram #(
      .WIDTH (SLOT_WIDTH),
      .DEPTH (HEAD_COUNT)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (ctrl.capture),
      .rd_addr (req_slot),
      .rd_data (head_q)
   );

   always_comb begin
      link_wr_en   = ctrl.add_write | ctrl.walk_fix;
      link_wr_addr = ctrl.walk_fix ? cur_ff.index[LINK_AW-1:0] : idx_ff[LINK_AW-1:0];
      link_wr_data = ctrl.walk_fix ? idx_link_ff : head_q;
      link_rd_en   = ctrl.capture | ctrl.walk_start | ctrl.walk_step;
      priority if (ctrl.capture) begin
         link_rd_addr = req_payload.entry_index[LINK_AW-1:0];
      end else if (ctrl.walk_start) begin
         link_rd_addr = head_q.index[LINK_AW-1:0];
      end else begin
         link_rd_addr = link_q.index[LINK_AW-1:0];
      end
   end

   chi_ram #(
      .WIDTH (SLOT_WIDTH),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_q)
   );

   // request and walk payload registers
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_payload.cmd;
         slot_ff <= req_slot;
         idx_ff  <= req_payload.entry_index;
      end
      if (ctrl.walk_start) begin
         cur_ff      <= head_q;
         idx_link_ff <= link_q;
      end else if (ctrl.walk_step) begin
         cur_ff <= link_q;
      end
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      steps_in = steps_ff;
      if (ctrl.walk_start) begin
         steps_in = '0;
      end else if (ctrl.walk_step) begin
         steps_in = steps_ff + 1'b1;
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (ctrl.sweep_write) begin
         sweep_in = stat.sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         sweep_ff  <= sweep_in;
         strobe_ff <= ctrl.respond;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (ctrl.respond) begin
         rsp_in = '0;
         unique case (ctrl.rsp_sel)
            RSP_NONE:  rsp_in = '0;
            RSP_RANGE: rsp_in.status = 1'b1;
            RSP_HEAD: begin
               rsp_in.result_valid = !head_q.empty;
               rsp_in.result_index = head_q.empty ? '0 : head_q.index;
            end
            RSP_LINK: begin
               rsp_in.result_valid = !link_q.empty;
               rsp_in.result_index = link_q.empty ? '0 : link_q.index;
            end
            default: rsp_in = '0;
         endcase
      end
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.in_range   = (32'(idx_ff) < 32'(INDEX_CAPACITY));
      stat.head_hit   = !head_q.empty && (head_q.index == idx_ff);
      stat.head_empty = head_q.empty;
      stat.link_hit   = !link_q.empty && (link_q.index == idx_ff);
      stat.link_empty = link_q.empty;
      stat.walk_last  = (steps_ff == STEP_W'(INDEX_CAPACITY - 1));
      stat.sweep_last = (sweep_ff == HEAD_AW'(HEAD_COUNT - 1));
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[src/chained_index_hash_table.sv]
// chained_index_hash_table: top level, controller plus datapath.
// Depends on chi_pkg, chi_ctrl, chi_datapath (and chi_ram below it).
//
// A request (cmd, key, entry_index) is taken at a clock edge with start high and
// busy low. Low key bits pick a head slot; commands push, unlink, read the head,
// read a successor, or empty all heads. Every request gives exactly one result,
// shown on rsp_payload for one cycle with rsp_strobe high; the receiver cannot
// stall it and must take it in that cycle.
// Sequence from the accepting edge to the result strobe:
//   add, first, next, unused codes, out-of-range index: execute state, then result
//   remove: execute state alone when the index heads its chain or the chain is
//           empty, otherwise a walk in which chain links are read, one per cycle
//           through the single link memory read port
//   clear:  every head slot written in the clear state, one head slot per cycle
// busy stays high from the accept until the result is registered, so a new
// request can be taken in the cycle the strobe is shown.
// After reset the head memory is swept to empty while busy is high. The link
// memory is not cleared.
`default_nettype none

module chained_index_hash_table
   import chi_pkg::*;
#(
   parameter int HEAD_COUNT     = DEF_HEAD_COUNT,
   parameter int INDEX_CAPACITY = DEF_INDEX_CAPACITY
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   ctrl_type ctrl;
   stat_type stat;

   chi_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_payload.cmd),
      .stat    (stat),
      .busy    (busy),
      .ctrl    (ctrl)
   );

   chi_datapath #(
      .HEAD_COUNT     (HEAD_COUNT),
      .INDEX_CAPACITY (INDEX_CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctrl        (ctrl),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting a request");

   a_strobe_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a request in progress");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two consecutive cycles");

   a_short_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.cmd == CMD_ADD || req_payload.cmd == CMD_FIRST
                          || req_payload.cmd == CMD_NEXT)) |=> ##1 rsp_strobe)
      else $error("add, first or next result not delivered in two cycles");

endmodule

`default_nettype wire
